// File: rtl/adw_pkg.sv
// ----------------------------------------------------------------------------
// adw_pkg
// shared types, register codes and the arctan table of the waveshaper
// ----------------------------------------------------------------------------
package adw_pkg;

  localparam int DRIVE_W    = 16;
  localparam int DRIVE_FRAC = 12;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int Z_W        = 32;
  localparam int ATAN_N     = 24;

  // shape mode codes
  localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HALF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ATAN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 1'd1;

  localparam logic [MODE_W-1:0]  MODE_RST  = MODE_ATAN;
  localparam logic [DRIVE_W-1:0] DRIVE_RST = 16'd4096;

  // atan(2^-i) with 2^30 standing for pi/2
  localparam logic signed [Z_W-1:0] ATAN_TBL [ATAN_N] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

  // control bits that travel with each word down the pipeline
  typedef struct packed {
    logic vld;
    logic atan;
    logic neg;
    logic zero;
  } adw_ctl_t;

endpackage

// File: rtl/audio_distortion_waveshaper_unit.sv
// ----------------------------------------------------------------------------
// audio_distortion_waveshaper_unit
// stateless waveshaper: full-wave, half-wave or arctan soft clip per sample
// ----------------------------------------------------------------------------
// pipeline: stage a, stage b, CORDIC_STEPS cordic stages, then the output register
// throughput: one word per cycle while the output is not stalled, set by the unrolled cordic pipeline
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// reset (rst_n, synchronous): clears all valid bits, shape mode to arctan,
// drive gain to 1.0
// ----------------------------------------------------------------------------
module audio_distortion_waveshaper_unit #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  // output stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [adw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [adw_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import adw_pkg::*;

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SB     = SAMPLE_BITS;
  // product of sample and drive, signed
  localparam int PROD_W = SB + DRIVE_W + 1;
  // cordic x/y width, leaves headroom for the cordic gain
  localparam int W      = SB + DRIVE_W + 2;
  // z to sample format alignment
  localparam int ZRSH   = (SB <= 31) ? 31 - SB : 0;
  localparam int ZLSH   = (SB > 31) ? SB - 31 : 0;
  localparam int ZHSH   = (ZRSH > 0) ? ZRSH - 1 : 0;
  localparam int MAG_W  = Z_W + 3;

  localparam logic signed [W-1:0]     CX0   = W'(1) <<< (SB - 1 + DRIVE_FRAC);
  localparam logic signed [MAG_W-1:0] ZHALF = (ZRSH > 0) ? (MAG_W'(1) <<< ZHSH) : '0;
  localparam logic signed [MAG_W-1:0] SMAX_M = (MAG_W'(1) <<< (SB - 1)) - MAG_W'(1);
  localparam logic [SB-1:0]           SMAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]           SMIN  = {1'b1, {(SB-1){1'b0}}};

  // configuration registers
  logic [MODE_W-1:0]  shape_mode_r;
  logic [DRIVE_W-1:0] drive_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r <= MODE_RST;
      drive_gain_r <= DRIVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE_MODE: shape_mode_r <= cfg_wdata[MODE_W-1:0];
        REG_DRIVE_GAIN: drive_gain_r <= cfg_wdata[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output slot is free or being drained
  logic adv;
  logic out_valid_r;
  logic [SB-1:0] out_data_r;

  assign adv       = ~out_valid_r | out_tready;
  assign in_tready = adv;

  // stage a: multiply by drive, rectifier result formed on the side
  logic signed [SB-1:0]     x_in;
  logic [SB-1:0]            byp_nxt;
  adw_ctl_t                 a_ctl_r;
  logic signed [PROD_W-1:0] a_prod_r;
  logic [SB-1:0]            a_byp_r;

  assign x_in = $signed(in_tdata[SB-1:0]);

  always_comb begin
    unique case (shape_mode_r)
      MODE_FULL: begin
        if (x_in == $signed(SMIN)) begin
          byp_nxt = SMAX;
        end else if (x_in[SB-1]) begin
          byp_nxt = -x_in;
        end else begin
          byp_nxt = x_in;
        end
      end
      // half-wave, also the unused code
      default: byp_nxt = (!x_in[SB-1] && (x_in != '0)) ? x_in : '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r.vld <= 1'b0;
    end else if (adv) begin
      a_ctl_r.vld <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctl_r.atan <= (shape_mode_r == MODE_ATAN);
      a_ctl_r.neg  <= 1'b0;
      a_ctl_r.zero <= 1'b0;
      a_prod_r     <= PROD_W'(x_in) * $signed({1'b0, drive_gain_r});
      a_byp_r      <= byp_nxt;
    end
  end

  // stage b: magnitude of the product, sign and zero flags
  logic signed [PROD_W-1:0] prod_abs;
  adw_ctl_t                 b_ctl_r;
  logic signed [W-1:0]      b_y_r;
  logic [SB-1:0]            b_byp_r;

  assign prod_abs = a_prod_r[PROD_W-1] ? -a_prod_r : a_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r.vld <= 1'b0;
    end else if (adv) begin
      b_ctl_r.vld <= a_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctl_r.atan <= a_ctl_r.atan;
      b_ctl_r.neg  <= a_prod_r[PROD_W-1];
      b_ctl_r.zero <= (a_prod_r == '0);
      b_y_r        <= W'(prod_abs);
      b_byp_r      <= a_byp_r;
    end
  end

  // cordic vectoring chain, one iteration per stage
  adw_ctl_t              c_ctl  [CORDIC_STEPS+1];
  logic [SB-1:0]         c_side [CORDIC_STEPS+1];
  logic signed [W-1:0]   c_x    [CORDIC_STEPS+1];
  logic signed [W-1:0]   c_y    [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] c_z    [CORDIC_STEPS+1];

  assign c_ctl[0]  = b_ctl_r;
  assign c_side[0] = b_byp_r;
  assign c_x[0]    = CX0;
  assign c_y[0]    = b_y_r;
  assign c_z[0]    = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    adw_cordic_stage #(
      .W      (W),
      .SIDE_W (SB),
      .IDX    (i)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .i_ctl  (c_ctl[i]),
      .i_side (c_side[i]),
      .i_x    (c_x[i]),
      .i_y    (c_y[i]),
      .i_z    (c_z[i]),
      .o_ctl  (c_ctl[i+1]),
      .o_side (c_side[i+1]),
      .o_x    (c_x[i+1]),
      .o_y    (c_y[i+1]),
      .o_z    (c_z[i+1])
    );
  end

  // output stage: round angle to sample format, clamp, apply sign, pick mode
  adw_ctl_t              l_ctl;
  logic signed [MAG_W-1:0] z_sum, mag, mag_sh;
  logic [SB-1:0]         mag_s, shaped, out_nxt;

  assign l_ctl = c_ctl[CORDIC_STEPS];

  always_comb begin
    z_sum = MAG_W'(c_z[CORDIC_STEPS]) + ZHALF;
    mag   = z_sum >>> ZRSH;
    if (mag[MAG_W-1]) begin
      mag = '0;
    end
    mag_sh = mag <<< ZLSH;
    if (mag_sh > SMAX_M) begin
      mag_s = SMAX;
    end else begin
      mag_s = mag_sh[SB-1:0];
    end
    shaped = l_ctl.neg ? -mag_s : mag_s;
    if (!l_ctl.atan) begin
      out_nxt = c_side[CORDIC_STEPS];
    end else if (l_ctl.zero) begin
      out_nxt = '0;
    end else begin
      out_nxt = shaped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= l_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);

endmodule

// File: rtl/adw_cordic_stage.sv
// ----------------------------------------------------------------------------
// adw_cordic_stage
// one registered cordic vectoring iteration with its side data
// ----------------------------------------------------------------------------
module adw_cordic_stage #(
  parameter int W      = 34,
  parameter int SIDE_W = 16,
  parameter int IDX    = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  adw_pkg::adw_ctl_t                 i_ctl,
  input  logic [SIDE_W-1:0]                 i_side,
  input  logic signed [W-1:0]               i_x,
  input  logic signed [W-1:0]               i_y,
  input  logic signed [adw_pkg::Z_W-1:0]    i_z,
  output adw_pkg::adw_ctl_t                 o_ctl,
  output logic [SIDE_W-1:0]                 o_side,
  output logic signed [W-1:0]               o_x,
  output logic signed [W-1:0]               o_y,
  output logic signed [adw_pkg::Z_W-1:0]    o_z
);
  import adw_pkg::*;

  logic signed [W-1:0]   dx, dy, x_nxt, y_nxt;
  logic signed [Z_W-1:0] z_nxt;
  logic                  up;
  adw_ctl_t              ctl_r;
  logic [SIDE_W-1:0]     side_r;
  logic signed [W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0] z_r;

  always_comb begin
    dx = i_y >>> IDX;
    dy = i_x >>> IDX;
    up = ~i_y[W-1];
    if (up) begin
      x_nxt = i_x + dx;
      y_nxt = i_y - dy;
      z_nxt = i_z + ATAN_TBL[IDX];
    end else begin
      x_nxt = i_x - dx;
      y_nxt = i_y + dy;
      z_nxt = i_z - ATAN_TBL[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r.vld <= i_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.atan <= i_ctl.atan;
      ctl_r.neg  <= i_ctl.neg;
      ctl_r.zero <= i_ctl.zero;
      side_r     <= i_side;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      z_r        <= z_nxt;
    end
  end

  assign o_ctl  = ctl_r;
  assign o_side = side_r;
  assign o_x    = x_r;
  assign o_y    = y_r;
  assign o_z    = z_r;

endmodule
